// ===== src/rbb_pkg.sv =====
// Shared types and constants for the RGB box blur unit.
// Depends on nothing; imported by rbb_lane, rbb_merge, the top level and rbb_checker.
`default_nettype none
package rbb_pkg;

   // Default sizing
   localparam int DEF_MAX_IMAGE_WIDTH  = 2048;
   localparam int DEF_MAX_IMAGE_HEIGHT = 2048;
   localparam int DEF_MAX_RADIUS       = 15;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int DIM_REG_W   = 12;
   localparam int RAD_REG_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

   localparam logic [DIM_REG_W-1:0] RST_IMAGE_WIDTH  = 12'd1;
   localparam logic [DIM_REG_W-1:0] RST_IMAGE_HEIGHT = 12'd1;
   localparam logic [RAD_REG_W-1:0] RST_BLUR_RADIUS  = 4'd10;

   // Beat kinds on the request side
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;

   // Control from the sequencer to every channel lane
   typedef struct packed {
      logic clear;
      logic acc_en;
      logic start;
   } lane_ctl_type;

endpackage
`default_nettype wire

// ===== src/rbb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module rbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/rbb_lane.sv =====
// One color channel lane: window accumulator and restoring divider.
// Depends on rbb_pkg.
`default_nettype none
module rbb_lane
   import rbb_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lane_ctl_type        ctl,
   input  wire logic [CHAN_W-1:0]   pix,
   input  wire logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] count,
   output      logic                done,
   output      logic [CHAN_W-1:0]   quot
);
   localparam int SPAN = 2 * MAX_RADIUS + 1;
   localparam int CW   = $clog2(SPAN * SPAN + 1);
   localparam int SW   = $clog2(SPAN * SPAN * 255 + 1);
   localparam int KW   = $clog2(SW + 1);

   logic [SW-1:0] sum_ff, sum_in;
   logic [SW-1:0] q_ff, q_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] div_ff, div_in;
   logic [KW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   shifted;

   // Accumulate, then shift one quotient bit per cycle
   always_comb begin
      sum_in  = sum_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      shifted = {rem_ff, q_ff[SW-1]};
      if (ctl.clear) begin
         sum_in  = '0;
         done_in = 1'b0;
      end else if (ctl.acc_en) begin
         sum_in = sum_ff + SW'(pix);
      end
      if (ctl.start) begin
         q_in    = sum_ff;
         rem_in  = '0;
         div_in  = count;
         step_in = KW'(SW);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = CW'(shifted - {1'b0, div_ff});
            q_in   = {q_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = shifted[CW-1:0];
            q_in   = {q_ff[SW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == KW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff[CHAN_W-1:0];
endmodule
`default_nettype wire

// ===== src/rbb_merge.sv =====
// Output stage: joins the three lane quotients into one result beat.
// Depends on rbb_pkg.
`default_nettype none
module rbb_merge
   import rbb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic [CHAN_W-1:0] red,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] blue,
   input  wire logic              last,
   output      logic              free,
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [PIX_W-1:0]  rsp_tdata,
   output      logic              rsp_tlast
);
   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] data_ff;
   logic             last_ff;

   assign free = !valid_ff || rsp_tready;

   // Hold the beat until taken
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {blue, green, red};
         last_ff <= last;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
endmodule
`default_nettype wire

// ===== src/rgb_box_blur_clamped_unit.sv =====
// RGB box blur with clipped square window, top level.
// Uses rbb_pkg, rbb_ram, rbb_lane and rbb_merge.
//
// Usage:
//  - req channel: one beat per pixel in raster order (tuser = 0), or a
//    drain beat (tuser = 1) that flushes one pending output.
//  - rsp channel: one blurred pixel per beat, tlast on the image's last.
//  - csr port: width, height, radius; latched at each image's first pixel.
// Each request beat produces at most one result beat. A beat that yields a
// result passes size (on an image's first pixel only), write, check,
// window, scan, last, divider start, divide and emit: the window is read
// from the line store one pixel per cycle over its single read port, then
// three channel lanes divide in parallel, one quotient bit a cycle.
// A beat that yields no result passes size (as above), write and check only.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the block stalls only when a second result is ready
// while the first one is still held by the receiver.
// Reset clears positions and control and loads register defaults;
// the line store keeps its contents and needs no clearing pass.
`default_nettype none
module rgb_box_blur_clamped_unit
   import rbb_pkg::*;
#(
   parameter int MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
   parameter int MAX_IMAGE_HEIGHT = DEF_MAX_IMAGE_HEIGHT,
   parameter int MAX_RADIUS       = DEF_MAX_RADIUS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [PIX_W-1:0]       req_tdata,  // red_in, green_in, blue_in
   input  wire logic                   req_tuser,  // func
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [PIX_W-1:0]       rsp_tdata,  // red_out, green_out, blue_out
   output      logic                   rsp_tlast,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);
   localparam int ROWS  = 2 * MAX_RADIUS + 2;
   localparam int DEPTH = ROWS * MAX_IMAGE_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = $clog2(MAX_IMAGE_WIDTH + 1);
   localparam int HW    = $clog2(MAX_IMAGE_HEIGHT + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int GW    = $clog2(ROWS);
   localparam int PW    = $clog2(MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT + 1);
   localparam int OW    = $clog2(MAX_RADIUS * MAX_IMAGE_WIDTH + MAX_RADIUS + 1);
   localparam int NW    = (PW > OW ? PW : OW) + 1;
   localparam int SPAN  = 2 * MAX_RADIUS + 1;
   localparam int CW    = $clog2(SPAN * SPAN + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SIZE   = 4'd1;
   localparam logic [3:0] S_WRITE  = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_WIN    = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_LAST   = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   // Configuration registers
   logic [DIM_REG_W-1:0] width_reg_ff, height_reg_ff;
   logic [RAD_REG_W-1:0] radius_reg_ff;

   // Sequencer state
   logic [3:0]       state_ff, state_in;
   logic             func_ff, func_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [DW-1:0]    cur_w_ff, cur_w_in;
   logic [HW-1:0]    cur_h_ff, cur_h_in;
   logic [RW-1:0]    cur_r_ff, cur_r_in;
   logic [PW-1:0]    total_ff, total_in;
   logic [OW-1:0]    reach_ff, reach_in;
   logic [PW-1:0]    ip_ff, ip_in;
   logic [PW-1:0]    op_ff, op_in;
   logic [DW-1:0]    wx_ff, wx_in;
   logic [GW-1:0]    wring_ff, wring_in;
   logic [DW-1:0]    ox_ff, ox_in;
   logic [HW-1:0]    oy_ff, oy_in;
   logic [GW-1:0]    oring_ff, oring_in;
   logic [DW-1:0]    sx_ff, sx_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [HW-1:0]    sy_ff, sy_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [GW-1:0]    sring_ff, sring_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             pend_ff;

   // Helpers
   logic [NW-1:0]    need, last_idx;
   logic [DW:0]      xr;
   logic [HW:0]      yr;
   logic [GW:0]      dy;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             lane_done [3];
   logic [CHAN_W-1:0] lane_q [3];
   lane_ctl_type     lane_ctl;
   logic             merge_free, merge_load, last_flag;
   logic [DW-1:0]    clamp_w;
   logic [HW-1:0]    clamp_h;
   logic [RW-1:0]    clamp_r;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= RST_IMAGE_WIDTH;
         height_reg_ff <= RST_IMAGE_HEIGHT;
         radius_reg_ff <= RST_BLUR_RADIUS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_reg_ff  <= csr_wdata[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg_ff <= csr_wdata[DIM_REG_W-1:0];
            REG_BLUR_RADIUS:  radius_reg_ff <= csr_wdata[RAD_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp image size and radius
   always_comb begin
      if (width_reg_ff == '0) begin
         clamp_w = DW'(1);
      end else if (32'(width_reg_ff) > MAX_IMAGE_WIDTH) begin
         clamp_w = DW'(MAX_IMAGE_WIDTH);
      end else begin
         clamp_w = DW'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         clamp_h = HW'(1);
      end else if (32'(height_reg_ff) > MAX_IMAGE_HEIGHT) begin
         clamp_h = HW'(MAX_IMAGE_HEIGHT);
      end else begin
         clamp_h = HW'(height_reg_ff);
      end
      if (32'(radius_reg_ff) > MAX_RADIUS) begin
         clamp_r = RW'(MAX_RADIUS);
      end else begin
         clamp_r = RW'(radius_reg_ff);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign wr_addr    = AW'(AW'(wring_ff) * AW'(MAX_IMAGE_WIDTH)) + AW'(wx_ff);
   assign rd_addr    = AW'(AW'(sring_ff) * AW'(MAX_IMAGE_WIDTH)) + AW'(sx_ff);
   assign wr_en      = (state_ff == S_WRITE) && (func_ff == FUNC_PIXEL) && (ip_ff < total_ff);
   assign last_idx   = NW'(total_ff) - NW'(1);
   assign need       = NW'(op_ff) + NW'(reach_ff);
   assign merge_load = (state_ff == S_EMIT) && merge_free;
   assign last_flag  = (NW'(op_ff) == last_idx);

   assign lane_ctl.clear  = (state_ff == S_WIN);
   assign lane_ctl.acc_en = pend_ff;
   assign lane_ctl.start  = (state_ff == S_DSTART);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      pix_in   = pix_ff;
      cur_w_in = cur_w_ff;
      cur_h_in = cur_h_ff;
      cur_r_in = cur_r_ff;
      total_in = total_ff;
      reach_in = reach_ff;
      ip_in    = ip_ff;
      op_in    = op_ff;
      wx_in    = wx_ff;
      wring_in = wring_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oring_in = oring_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      y0_in    = y0_ff;
      y1_in    = y1_ff;
      sring_in = sring_ff;
      cnt_in   = cnt_ff;
      xr       = (DW+1)'(ox_ff) + (DW+1)'(cur_r_ff);
      yr       = (HW+1)'(oy_ff) + (HW+1)'(cur_r_ff);
      dy       = (32'(oy_ff) > 32'(cur_r_ff)) ? (GW+1)'(cur_r_ff) : (GW+1)'(oy_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               pix_in   = req_tdata;
               state_in = S_WRITE;
               if (req_tuser == FUNC_PIXEL && ip_ff == '0) begin
                  cur_w_in = clamp_w;
                  cur_h_in = clamp_h;
                  cur_r_in = clamp_r;
                  state_in = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            total_in = PW'(PW'(cur_w_ff) * PW'(cur_h_ff));
            reach_in = OW'(OW'(cur_r_ff) * OW'(cur_w_ff)) + OW'(cur_r_ff);
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (wr_en) begin
               ip_in = ip_ff + 1'b1;
               if (wx_ff == cur_w_ff - 1'b1) begin
                  wx_in    = '0;
                  wring_in = (32'(wring_ff) == ROWS - 1) ? '0 : wring_ff + 1'b1;
               end else begin
                  wx_in = wx_ff + 1'b1;
               end
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_IDLE;
            if (ip_ff != '0 && op_ff < total_ff &&
                ((need > last_idx) ? last_idx : need) < NW'(ip_ff)) begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            // Clip the window to the image
            x0_in = (32'(ox_ff) > 32'(cur_r_ff)) ? ox_ff - DW'(cur_r_ff) : '0;
            y0_in = (32'(oy_ff) > 32'(cur_r_ff)) ? oy_ff - HW'(cur_r_ff) : '0;
            x1_in = (xr < (DW+1)'(cur_w_ff) - 1'b1) ? DW'(xr) : cur_w_ff - 1'b1;
            y1_in = (yr < (HW+1)'(cur_h_ff) - 1'b1) ? HW'(yr) : cur_h_ff - 1'b1;
            sx_in = x0_in;
            sy_in = y0_in;
            sring_in = ((GW+1)'(oring_ff) >= dy) ? GW'((GW+1)'(oring_ff) - dy)
                                                  : GW'((GW+1)'(oring_ff) + (GW+1)'(ROWS) - dy);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sx_ff == x1_ff) begin
               sx_in = x0_ff;
               if (sy_ff == y1_ff) begin
                  state_in = S_LAST;
               end else begin
                  sy_in    = sy_ff + 1'b1;
                  sring_in = (32'(sring_ff) == ROWS - 1) ? '0 : sring_ff + 1'b1;
               end
            end else begin
               sx_in = sx_ff + 1'b1;
            end
         end
         S_LAST: begin
            cnt_in   = CW'(CW'(y1_ff - y0_ff + 1'b1) * CW'(x1_ff - x0_ff + 1'b1));
            state_in = S_DSTART;
         end
         S_DSTART: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (lane_done[0] && lane_done[1] && lane_done[2]) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (merge_free) begin
               state_in = S_IDLE;
               if (last_flag) begin
                  // Image done: rewind both positions
                  op_in    = '0;
                  ip_in    = '0;
                  wx_in    = '0;
                  wring_in = '0;
                  ox_in    = '0;
                  oy_in    = '0;
                  oring_in = '0;
               end else begin
                  op_in = op_ff + 1'b1;
                  if (ox_ff == cur_w_ff - 1'b1) begin
                     ox_in    = '0;
                     oy_in    = oy_ff + 1'b1;
                     oring_in = (32'(oring_ff) == ROWS - 1) ? '0 : oring_ff + 1'b1;
                  end else begin
                     ox_in = ox_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_in_hold: begin
         func_ff  <= func_in;
         pix_ff   <= pix_in;
         reach_ff <= reach_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         x0_ff    <= x0_in;
         x1_ff    <= x1_in;
         y0_ff    <= y0_in;
         y1_ff    <= y1_in;
         sring_ff <= sring_in;
         cnt_ff   <= cnt_in;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         cur_w_ff <= DW'(1);
         cur_h_ff <= HW'(1);
         cur_r_ff <= '0;
         total_ff <= PW'(1);
         ip_ff    <= '0;
         op_ff    <= '0;
         wx_ff    <= '0;
         wring_ff <= '0;
         ox_ff    <= '0;
         oy_ff    <= '0;
         oring_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_w_ff <= cur_w_in;
         cur_h_ff <= cur_h_in;
         cur_r_ff <= cur_r_in;
         total_ff <= total_in;
         ip_ff    <= ip_in;
         op_ff    <= op_in;
         wx_ff    <= wx_in;
         wring_ff <= wring_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         oring_ff <= oring_in;
         pend_ff  <= (state_ff == S_SCAN);
      end
   end

   // Line store
   rbb_ram #(
      .WIDTH(PIX_W),
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pix_ff),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One lane per color channel
   for (genvar g = 0; g < 3; g++) begin : g_lane
      rbb_lane #(
         .MAX_RADIUS(MAX_RADIUS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .pix   (rd_data[g*CHAN_W +: CHAN_W]),
         .count (cnt_ff),
         .done  (lane_done[g]),
         .quot  (lane_q[g])
      );
   end

   rbb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .red        (lane_q[0]),
      .green      (lane_q[1]),
      .blue       (lane_q[2]),
      .last       (last_flag),
      .free       (merge_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

// ===== src/rbb_checker.sv =====
// Port-level checks for the box blur unit, bound to the top level.
// Depends on rbb_pkg and rgb_box_blur_clamped_unit.
`default_nettype none
module rbb_checker
   import rbb_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [PIX_W-1:0]       rsp_tdata,
   input wire logic                   rsp_tlast
);
   // No result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Request beats are spaced by the sequencer
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back to back request beats");

   // A result never appears the cycle after a request beat
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result too soon after request");
endmodule

bind rgb_box_blur_clamped_unit rbb_checker u_rbb_checker (.*);
`default_nettype wire
